@@ rtl/rnt_pkg.sv @@
package rnt_pkg;

    // Fixed sizes of the hash index and of the word fields.
    localparam int INDEX_ENTRIES = 256;
    localparam int HASH_W        = 8;
    localparam int MAC_W         = 48;
    localparam int AGE_W         = 16;
    localparam int KIND_W        = 2;
    localparam int NODE_WORD_W   = KIND_W + 3 * AGE_W;

    // Defaults for the top-level parameters.
    localparam int DEF_BIN_ENTRIES  = 128;
    localparam int DEF_NODE_ENTRIES = 128;
    localparam int DEF_MAX_AGE      = 65535;

    localparam logic [15:0] FORGET_RESET = 16'hFFFF;

    // Command codes.
    localparam logic [1:0] CMD_LEARN = 2'd0;
    localparam logic [1:0] CMD_TICK  = 2'd1;
    localparam logic [1:0] CMD_PURGE = 2'd2;

    // Result codes.
    localparam logic [1:0] RES_NEW   = 2'd0;
    localparam logic [1:0] RES_KNOWN = 2'd1;
    localparam logic [1:0] RES_FULL  = 2'd2;

    // Node kinds.
    localparam logic [1:0] KIND_SAN_A   = 2'd0;
    localparam logic [1:0] KIND_SAN_B   = 2'd1;
    localparam logic [1:0] KIND_DAN_PRP = 2'd2;
    localparam logic [1:0] KIND_DAN_HSR = 2'd3;

    // Operation of one bin cell in a cycle.
    typedef enum logic [2:0] {
        OP_HOLD,
        OP_FROM_LOWER,
        OP_FROM_UPPER,
        OP_LOAD,
        OP_CLEAR
    } cell_op_t;

    // Write controls of the node store.
    typedef struct packed {
        logic wr_en;
        logic set_taken;
        logic clr_taken;
    } node_ctl_t;

    // Write controls of the hash index.
    typedef struct packed {
        logic off_we;
        logic cnt_we;
    } idx_ctl_t;

    // XOR of the six address bytes.
    function automatic logic [HASH_W-1:0] addr_hash(input logic [MAC_W-1:0] a);
        logic [HASH_W-1:0] h;
        h = '0;
        for (int k = 0; k < 6; k++) begin
            h = h ^ a[8*k +: 8];
        end
        return h;
    endfunction

endpackage

@@ rtl/rnt_bin_cell.sv @@
module rnt_bin_cell #(
    parameter int NODE_ENTRIES = rnt_pkg::DEF_NODE_ENTRIES,
    localparam int NVW = $clog2(NODE_ENTRIES + 1)
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  rnt_pkg::cell_op_t          op,
    input  logic [rnt_pkg::MAC_W-1:0]  ld_addr,
    input  logic [NVW-1:0]             ld_ptr,
    input  logic [rnt_pkg::MAC_W-1:0]  lo_addr,
    input  logic [NVW-1:0]             lo_ptr,
    input  logic [rnt_pkg::MAC_W-1:0]  hi_addr,
    input  logic [NVW-1:0]             hi_ptr,
    input  logic [rnt_pkg::MAC_W-1:0]  mac,
    output logic [rnt_pkg::MAC_W-1:0]  addr,
    output logic [NVW-1:0]             ptr,
    output logic                       empty,
    output logic                       match,
    output logic [rnt_pkg::HASH_W-1:0] hash
);
    import rnt_pkg::*;

    localparam logic [NVW-1:0] PTR_NONE = NVW'(NODE_ENTRIES);

    logic [MAC_W-1:0] addr_reg;
    logic [NVW-1:0]   ptr_reg;

    // One bin: load, take a neighbor's contents, or drop the node pointer.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            addr_reg <= '0;
            ptr_reg  <= PTR_NONE;
        end
        else
        begin
            case (op)
                OP_LOAD:
                begin
                    addr_reg <= ld_addr;
                    ptr_reg  <= ld_ptr;
                end
                OP_FROM_LOWER:
                begin
                    addr_reg <= lo_addr;
                    ptr_reg  <= lo_ptr;
                end
                OP_FROM_UPPER:
                begin
                    addr_reg <= hi_addr;
                    ptr_reg  <= hi_ptr;
                end
                OP_CLEAR:
                begin
                    ptr_reg <= PTR_NONE;
                end
                default:
                begin
                    addr_reg <= addr_reg;
                end
            endcase
        end
    end

    // Local status seen by the sequencer.
    assign addr  = addr_reg;
    assign ptr   = ptr_reg;
    assign empty = (ptr_reg >= PTR_NONE);
    assign match = (addr_reg == mac) && !empty;
    assign hash  = addr_hash(addr_reg);

endmodule

@@ rtl/rnt_index_mem.sv @@
module rnt_index_mem #(
    parameter int BIN_ENTRIES = rnt_pkg::DEF_BIN_ENTRIES,
    localparam int BVW = $clog2(BIN_ENTRIES + 1)
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  rnt_pkg::idx_ctl_t          ctl,
    input  logic [rnt_pkg::HASH_W-1:0] ra,
    input  logic [rnt_pkg::HASH_W-1:0] off_wa,
    input  logic [BVW-1:0]             off_wd,
    input  logic [rnt_pkg::HASH_W-1:0] cnt_wa,
    input  logic [BVW-1:0]             cnt_wd,
    output logic [BVW-1:0]             off,
    output logic [BVW-1:0]             cnt,
    output logic                       clearing
);
    import rnt_pkg::*;

    localparam logic [BVW-1:0] OFF_EMPTY = BVW'(BIN_ENTRIES);

    logic [BVW-1:0]    off_mem [INDEX_ENTRIES];
    logic [BVW-1:0]    cnt_mem [INDEX_ENTRIES];
    logic [BVW-1:0]    off_q_reg;
    logic [BVW-1:0]    cnt_q_reg;
    logic [HASH_W-1:0] clr_addr_reg;
    logic              clearing_reg;

    // Clearing pass after reset: one entry per cycle over the whole index.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_addr_reg <= '0;
            clearing_reg <= 1'b1;
        end
        else if (clearing_reg)
        begin
            clr_addr_reg <= clr_addr_reg + HASH_W'(1);
            if (clr_addr_reg == '1)
            begin
                clearing_reg <= 1'b0;
            end
        end
    end

    // Storage with registered read; the clearing pass owns the write ports.
    always_ff @(posedge clk)
    begin
        if (clearing_reg)
        begin
            off_mem[clr_addr_reg] <= OFF_EMPTY;
            cnt_mem[clr_addr_reg] <= '0;
        end
        else
        begin
            if (ctl.off_we)
            begin
                off_mem[off_wa] <= off_wd;
            end
            if (ctl.cnt_we)
            begin
                cnt_mem[cnt_wa] <= cnt_wd;
            end
        end
        off_q_reg <= off_mem[ra];
        cnt_q_reg <= cnt_mem[ra];
    end

    assign off      = off_q_reg;
    assign cnt      = cnt_q_reg;
    assign clearing = clearing_reg;

endmodule

@@ rtl/rnt_node_mem.sv @@
module rnt_node_mem #(
    parameter int NODE_ENTRIES = rnt_pkg::DEF_NODE_ENTRIES,
    localparam int NIW = $clog2(NODE_ENTRIES)
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  rnt_pkg::node_ctl_t              ctl,
    input  logic [NIW-1:0]                  wa,
    input  logic [rnt_pkg::NODE_WORD_W-1:0] wd,
    input  logic [NIW-1:0]                  ra,
    output logic [rnt_pkg::NODE_WORD_W-1:0] rd,
    output logic [NODE_ENTRIES-1:0]         taken
);
    import rnt_pkg::*;

    logic [NODE_WORD_W-1:0]  node_mem [NODE_ENTRIES];
    logic [NODE_WORD_W-1:0]  rd_reg;
    logic [NODE_ENTRIES-1:0] taken_reg;

    // Kind and age counters of each node slot.
    always_ff @(posedge clk)
    begin
        if (ctl.wr_en)
        begin
            node_mem[wa] <= wd;
        end
        rd_reg <= node_mem[ra];
    end

    // Slot occupancy flags.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            taken_reg <= '0;
        end
        else if (ctl.set_taken)
        begin
            taken_reg[wa] <= 1'b1;
        end
        else if (ctl.clr_taken)
        begin
            taken_reg[wa] <= 1'b0;
        end
    end

    assign rd    = rd_reg;
    assign taken = taken_reg;

endmodule

@@ rtl/redundancy_node_table.sv @@
// Node table for redundant Ethernet (PRP / HSR).
// Input channel: a word is taken at a rising edge with start high and busy low.
// cmd selects learn (mac, port_a, sup_frame, proto), age tick, or purge.
// Output channel: done is high for exactly one cycle with result_code,
// node_slot, node_count and removed_count; the receiver cannot stall it.
// The expiry limit is written through cfg_wr_en / cfg_wr_data; the user must
// write it only while idle, as the block itself does not enforce this.
// Bins are a row of cells that all shift to their neighbors together.
// Learn reads the index entry, scans the run, finds a free bin for a new
// hash, a free slot and a hole, then re-indexes the moved bins; tick reads
// and writes back the node of each occupied bin; purge reads and checks
// each occupied node and reads the index entry for a removal. The walks go
// bin by bin over the cell row, and the node store has a single read port.
// A new word is taken in the cycle in which done is shown. Unused cmd codes
// answer in the cycle after acceptance. Reset empties all bins, frees all
// slots and sets the expiry limit to 65535; the hash index is then cleared
// one entry per cycle, so busy stays high until all 256 entries are cleared.
module redundancy_node_table #(
    parameter int BIN_ENTRIES  = rnt_pkg::DEF_BIN_ENTRIES,
    parameter int NODE_ENTRIES = rnt_pkg::DEF_NODE_ENTRIES,
    parameter int MAX_AGE      = rnt_pkg::DEF_MAX_AGE
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  cmd,
    input  logic [47:0] mac,
    input  logic        port_a,
    input  logic        sup_frame,
    input  logic        proto,
    output logic        done,
    output logic [1:0]  result_code,
    output logic [7:0]  node_slot,
    output logic [7:0]  node_count,
    output logic [7:0]  removed_count,
    input  logic        cfg_wr_en,
    input  logic [15:0] cfg_wr_data
);
    import rnt_pkg::*;

    localparam int BIW = $clog2(BIN_ENTRIES);
    localparam int BVW = $clog2(BIN_ENTRIES + 1);
    localparam int BXW = BVW + 1;
    localparam int NIW = $clog2(NODE_ENTRIES);
    localparam int NVW = $clog2(NODE_ENTRIES + 1);

    localparam logic [BXW-1:0]   BIN_X     = BXW'(BIN_ENTRIES);
    localparam logic [BVW-1:0]   BIN_V     = BVW'(BIN_ENTRIES);
    localparam logic [NVW-1:0]   NODE_V    = NVW'(NODE_ENTRIES);
    localparam logic [7:0]       SLOT_NONE = 8'(NODE_ENTRIES);
    localparam logic [AGE_W-1:0] AGE_MAX   = AGE_W'(MAX_AGE);

    typedef enum logic [3:0] {
        S_IDLE,
        L_IDX,
        L_SCAN,
        L_FEMPTY,
        L_NODE,
        L_EUP,
        L_EDN,
        L_REIDX,
        L_FIN,
        T_RD,
        T_WR,
        P_RD,
        P_CHK,
        P_IDX
    } state_t;

    function automatic logic [AGE_W-1:0] age_inc(input logic [AGE_W-1:0] a);
        return (a < AGE_MAX) ? a + AGE_W'(1) : AGE_MAX;
    endfunction

    // Registers.
    state_t           state_reg, state_next;
    logic [MAC_W-1:0] mac_reg, mac_next;
    logic [1:0]       kind_reg, kind_next;
    logic [HASH_W-1:0] h_reg, h_next;
    logic [BVW-1:0]   cnt_reg, cnt_next;
    logic [BXW-1:0]   b_reg, b_next;
    logic [BXW-1:0]   end_reg, end_next;
    logic [BVW-1:0]   idx_reg, idx_next;
    logic [BVW-1:0]   e_reg, e_next;
    logic [NVW-1:0]   n_reg, n_next;
    logic [NIW-1:0]   fn_reg, fn_next;
    logic [HASH_W-1:0] prev_reg, prev_next;
    logic             prev_v_reg, prev_v_next;
    logic             setpos_reg, setpos_next;
    logic [BVW-1:0]   live_reg, live_next;
    logic [7:0]       removed_reg, removed_next;
    logic             done_reg, done_next;
    logic [1:0]       code_reg, code_next;
    logic [7:0]       slot_reg, slot_next;
    logic [7:0]       count_out_reg, count_out_next;
    logic [15:0]      ft_reg;

    // Cell row.
    cell_op_t          cell_op   [BIN_ENTRIES];
    logic [MAC_W-1:0]  cell_addr [BIN_ENTRIES];
    logic [NVW-1:0]    cell_ptr  [BIN_ENTRIES];
    logic [HASH_W-1:0] cell_hash [BIN_ENTRIES];
    logic [MAC_W-1:0]  lo_addr   [BIN_ENTRIES];
    logic [NVW-1:0]    lo_ptr    [BIN_ENTRIES];
    logic [MAC_W-1:0]  hi_addr   [BIN_ENTRIES];
    logic [NVW-1:0]    hi_ptr    [BIN_ENTRIES];
    logic [BIN_ENTRIES-1:0] cell_empty;
    logic [BIN_ENTRIES-1:0] cell_match;

    // Row controls from the sequencer.
    logic           ld_en;
    logic [BIW-1:0] ld_idx;
    logic           clr_en;
    logic [BIW-1:0] clr_idx;
    cell_op_t       cp_dir;
    logic [BXW-1:0] cp_lo;
    logic [BXW-1:0] cp_hi;

    // Store ports.
    idx_ctl_t          idx_ctl;
    logic [HASH_W-1:0] idx_ra, off_wa, cnt_wa;
    logic [BVW-1:0]    off_wd, cnt_wd, idx_off, idx_cnt;
    logic              idx_clearing;
    node_ctl_t         node_ctl;
    logic [NIW-1:0]    node_wa, node_ra;
    logic [NODE_WORD_W-1:0] node_wd, node_rd;
    logic [NODE_ENTRIES-1:0] taken;

    // Helpers.
    logic [BIW-1:0]   bsel, esel;
    logic [BXW-1:0]   p_sum, p_end;
    logic [1:0]       rd_kind;
    logic [AGE_W-1:0] rd_s, rd_a, rd_b;
    logic             expired;

    generate
        for (genvar k = 0; k < BIN_ENTRIES; k++)
        begin : g_cell
            if (k == 0)
            begin : g_first
                assign lo_addr[k] = '0;
                assign lo_ptr[k]  = NODE_V;
            end
            else
            begin : g_lo
                assign lo_addr[k] = cell_addr[k-1];
                assign lo_ptr[k]  = cell_ptr[k-1];
            end
            if (k == BIN_ENTRIES - 1)
            begin : g_last
                assign hi_addr[k] = '0;
                assign hi_ptr[k]  = NODE_V;
            end
            else
            begin : g_hi
                assign hi_addr[k] = cell_addr[k+1];
                assign hi_ptr[k]  = cell_ptr[k+1];
            end

            rnt_bin_cell #(
                .NODE_ENTRIES(NODE_ENTRIES)
            ) u_cell (
                .clk    (clk),
                .rst_n  (rst_n),
                .op     (cell_op[k]),
                .ld_addr(mac_reg),
                .ld_ptr (NVW'(fn_reg)),
                .lo_addr(lo_addr[k]),
                .lo_ptr (lo_ptr[k]),
                .hi_addr(hi_addr[k]),
                .hi_ptr (hi_ptr[k]),
                .mac    (mac_reg),
                .addr   (cell_addr[k]),
                .ptr    (cell_ptr[k]),
                .empty  (cell_empty[k]),
                .match  (cell_match[k]),
                .hash   (cell_hash[k])
            );
        end
    endgenerate

    rnt_index_mem #(
        .BIN_ENTRIES(BIN_ENTRIES)
    ) u_index (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl     (idx_ctl),
        .ra      (idx_ra),
        .off_wa  (off_wa),
        .off_wd  (off_wd),
        .cnt_wa  (cnt_wa),
        .cnt_wd  (cnt_wd),
        .off     (idx_off),
        .cnt     (idx_cnt),
        .clearing(idx_clearing)
    );

    rnt_node_mem #(
        .NODE_ENTRIES(NODE_ENTRIES)
    ) u_node (
        .clk  (clk),
        .rst_n(rst_n),
        .ctl  (node_ctl),
        .wa   (node_wa),
        .wd   (node_wd),
        .ra   (node_ra),
        .rd   (node_rd),
        .taken(taken)
    );

    // Per-cell operation from the load, clear and copy ranges.
    always_comb
    begin
        for (int k = 0; k < BIN_ENTRIES; k++)
        begin
            if (ld_en && (BIW'(k) == ld_idx))
            begin
                cell_op[k] = OP_LOAD;
            end
            else if (clr_en && (BIW'(k) == clr_idx))
            begin
                cell_op[k] = OP_CLEAR;
            end
            else if ((BXW'(k) >= cp_lo) && (BXW'(k) < cp_hi))
            begin
                cell_op[k] = cp_dir;
            end
            else
            begin
                cell_op[k] = OP_HOLD;
            end
        end
    end

    // Decoded node word and expiry test.
    assign bsel    = b_reg[BIW-1:0];
    assign esel    = e_reg[BIW-1:0];
    assign rd_kind = node_rd[NODE_WORD_W-1 -: KIND_W];
    assign rd_s    = node_rd[3*AGE_W-1 -: AGE_W];
    assign rd_a    = node_rd[2*AGE_W-1 -: AGE_W];
    assign rd_b    = node_rd[AGE_W-1:0];
    assign expired = ((rd_s > ft_reg) || (rd_kind < KIND_DAN_PRP))
                     && (rd_a > ft_reg) && (rd_b > ft_reg);

    // Last bin of the run that holds the expired node.
    assign p_sum = BXW'(idx_off) + BXW'(idx_cnt) - BXW'(1);
    assign p_end = (p_sum >= BIN_X) ? BIN_X - BXW'(1) : p_sum;

    // Sequencer next state and store controls.
    always_comb
    begin
        state_next   = state_reg;
        mac_next     = mac_reg;
        kind_next    = kind_reg;
        h_next       = h_reg;
        cnt_next     = cnt_reg;
        b_next       = b_reg;
        end_next     = end_reg;
        idx_next     = idx_reg;
        e_next       = e_reg;
        n_next       = n_reg;
        fn_next      = fn_reg;
        prev_next    = prev_reg;
        prev_v_next  = prev_v_reg;
        setpos_next  = setpos_reg;
        live_next    = live_reg;
        removed_next = removed_reg;
        done_next    = 1'b0;
        code_next    = code_reg;
        slot_next    = slot_reg;

        ld_en   = 1'b0;
        ld_idx  = '0;
        clr_en  = 1'b0;
        clr_idx = '0;
        cp_dir  = OP_HOLD;
        cp_lo   = '0;
        cp_hi   = '0;

        idx_ctl  = '0;
        idx_ra   = h_reg;
        off_wa   = h_reg;
        off_wd   = '0;
        cnt_wa   = h_reg;
        cnt_wd   = '0;
        node_ctl = '0;
        node_wa  = cell_ptr[bsel][NIW-1:0];
        node_wd  = '0;
        node_ra  = cell_ptr[bsel][NIW-1:0];

        case (state_reg)
            S_IDLE:
            begin
                if (start && !idx_clearing)
                begin
                    mac_next     = mac;
                    h_next       = addr_hash(mac);
                    idx_ra       = addr_hash(mac);
                    removed_next = '0;
                    b_next       = '0;
                    if (sup_frame)
                    begin
                        kind_next = proto ? KIND_DAN_HSR : KIND_DAN_PRP;
                    end
                    else
                    begin
                        kind_next = port_a ? KIND_SAN_A : KIND_SAN_B;
                    end
                    case (cmd)
                        CMD_LEARN: state_next = L_IDX;
                        CMD_TICK:  state_next = T_RD;
                        CMD_PURGE: state_next = P_RD;
                        default:
                        begin
                            done_next = 1'b1;
                            code_next = RES_NEW;
                            slot_next = SLOT_NONE;
                        end
                    endcase
                end
            end

            // Index entry of the hash is now readable.
            L_IDX:
            begin
                cnt_next = idx_cnt;
                if (idx_cnt != '0)
                begin
                    b_next     = BXW'(idx_off);
                    end_next   = BXW'(idx_off) + BXW'(idx_cnt);
                    state_next = L_SCAN;
                end
                else
                begin
                    b_next     = '0;
                    state_next = L_FEMPTY;
                end
            end

            // Look for the address inside its run.
            L_SCAN:
            begin
                if ((b_reg < end_reg) && (b_reg < BIN_X))
                begin
                    if (cell_match[bsel])
                    begin
                        done_next  = 1'b1;
                        code_next  = RES_KNOWN;
                        slot_next  = 8'(cell_ptr[bsel]);
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        b_next = b_reg + BXW'(1);
                    end
                end
                else
                begin
                    idx_next   = (end_reg > BIN_X) ? BIN_V : BVW'(end_reg);
                    n_next     = '0;
                    state_next = L_NODE;
                end
            end

            // New hash: the run starts at the first empty bin.
            L_FEMPTY:
            begin
                if (b_reg < BIN_X)
                begin
                    if (cell_empty[bsel])
                    begin
                        idx_next   = BVW'(b_reg);
                        n_next     = '0;
                        state_next = L_NODE;
                    end
                    else
                    begin
                        b_next = b_reg + BXW'(1);
                    end
                end
                else
                begin
                    done_next  = 1'b1;
                    code_next  = RES_FULL;
                    slot_next  = SLOT_NONE;
                    state_next = S_IDLE;
                end
            end

            // First free node slot.
            L_NODE:
            begin
                if (n_reg < NODE_V)
                begin
                    if (!taken[n_reg[NIW-1:0]])
                    begin
                        fn_next = n_reg[NIW-1:0];
                        if (live_reg >= BIN_V)
                        begin
                            done_next  = 1'b1;
                            code_next  = RES_FULL;
                            slot_next  = SLOT_NONE;
                            state_next = S_IDLE;
                        end
                        else
                        begin
                            e_next     = idx_reg;
                            state_next = L_EUP;
                        end
                    end
                    else
                    begin
                        n_next = n_reg + NVW'(1);
                    end
                end
                else
                begin
                    done_next  = 1'b1;
                    code_next  = RES_FULL;
                    slot_next  = SLOT_NONE;
                    state_next = S_IDLE;
                end
            end

            // Hole at or above the insert point: shift the bins up one.
            L_EUP:
            begin
                if ((e_reg < BIN_V) && !cell_empty[esel])
                begin
                    e_next = e_reg + BVW'(1);
                end
                else if (e_reg < BIN_V)
                begin
                    ld_en       = 1'b1;
                    ld_idx      = idx_reg[BIW-1:0];
                    cp_dir      = OP_FROM_LOWER;
                    cp_lo       = BXW'(idx_reg) + BXW'(1);
                    cp_hi       = BXW'(e_reg) + BXW'(1);
                    b_next      = BXW'(idx_reg) + BXW'(1);
                    end_next    = BXW'(e_reg);
                    prev_v_next = 1'b0;
                    setpos_next = (cnt_reg == '0);
                    state_next  = L_REIDX;
                end
                else if (idx_reg == '0)
                begin
                    done_next  = 1'b1;
                    code_next  = RES_FULL;
                    slot_next  = SLOT_NONE;
                    state_next = S_IDLE;
                end
                else
                begin
                    e_next     = idx_reg - BVW'(1);
                    state_next = L_EDN;
                end
            end

            // Hole below the insert point: shift the bins down one.
            L_EDN:
            begin
                if ((e_reg != '0) && !cell_empty[esel])
                begin
                    e_next = e_reg - BVW'(1);
                end
                else if (!cell_empty[esel])
                begin
                    done_next  = 1'b1;
                    code_next  = RES_FULL;
                    slot_next  = SLOT_NONE;
                    state_next = S_IDLE;
                end
                else
                begin
                    ld_en       = 1'b1;
                    ld_idx      = BIW'(idx_reg - BVW'(1));
                    cp_dir      = OP_FROM_UPPER;
                    cp_lo       = BXW'(e_reg);
                    cp_hi       = BXW'(idx_reg) - BXW'(1);
                    b_next      = BXW'(e_reg);
                    end_next    = BXW'(idx_reg) - BXW'(1);
                    prev_v_next = 1'b0;
                    setpos_next = 1'b0;
                    state_next  = L_REIDX;
                end
            end

            // Rewrite run starts over the moved bins.
            L_REIDX:
            begin
                if (b_reg <= end_reg)
                begin
                    if (!prev_v_reg || (cell_hash[bsel] != prev_reg))
                    begin
                        idx_ctl.off_we = 1'b1;
                        off_wa         = cell_hash[bsel];
                        off_wd         = BVW'(b_reg);
                    end
                    prev_next   = cell_hash[bsel];
                    prev_v_next = 1'b1;
                    b_next      = b_reg + BXW'(1);
                end
                else
                begin
                    state_next = L_FIN;
                end
            end

            // Commit the run count and the new node.
            L_FIN:
            begin
                idx_ctl.off_we     = setpos_reg;
                off_wd             = idx_reg;
                idx_ctl.cnt_we     = 1'b1;
                cnt_wd             = cnt_reg + BVW'(1);
                node_ctl.wr_en     = 1'b1;
                node_ctl.set_taken = 1'b1;
                node_wa            = fn_reg;
                node_wd            = {kind_reg, {(3 * AGE_W){1'b0}}};
                live_next          = live_reg + BVW'(1);
                done_next          = 1'b1;
                code_next          = RES_NEW;
                slot_next          = 8'(fn_reg);
                state_next         = S_IDLE;
            end

            // Aging walk: read the node of an occupied bin.
            T_RD:
            begin
                if (b_reg < BIN_X)
                begin
                    if (!cell_empty[bsel])
                    begin
                        state_next = T_WR;
                    end
                    else
                    begin
                        b_next = b_reg + BXW'(1);
                    end
                end
                else
                begin
                    done_next  = 1'b1;
                    code_next  = RES_NEW;
                    slot_next  = SLOT_NONE;
                    state_next = S_IDLE;
                end
            end

            // Aging walk: write back the counters.
            T_WR:
            begin
                node_ctl.wr_en = 1'b1;
                node_wd = {rd_kind,
                           (rd_kind >= KIND_DAN_PRP) ? age_inc(rd_s) : rd_s,
                           age_inc(rd_a), age_inc(rd_b)};
                b_next     = b_reg + BXW'(1);
                state_next = T_RD;
            end

            // Purge walk: read the node of an occupied bin.
            P_RD:
            begin
                if (b_reg < BIN_X)
                begin
                    if (!cell_empty[bsel])
                    begin
                        state_next = P_CHK;
                    end
                    else
                    begin
                        b_next = b_reg + BXW'(1);
                    end
                end
                else
                begin
                    done_next  = 1'b1;
                    code_next  = RES_NEW;
                    slot_next  = SLOT_NONE;
                    state_next = S_IDLE;
                end
            end

            // Expired nodes fetch the index entry of their hash.
            P_CHK:
            begin
                if (expired)
                begin
                    idx_ra     = cell_hash[bsel];
                    state_next = P_IDX;
                end
                else
                begin
                    b_next     = b_reg + BXW'(1);
                    state_next = P_RD;
                end
            end

            // Remove the bin, close the run and free the slot; recheck this bin.
            P_IDX:
            begin
                if (idx_cnt == '0)
                begin
                    b_next = b_reg + BXW'(1);
                end
                else
                begin
                    cp_dir  = OP_FROM_UPPER;
                    cp_lo   = b_reg;
                    cp_hi   = p_end;
                    clr_en  = (p_end >= b_reg);
                    clr_idx = p_end[BIW-1:0];
                    idx_ctl.cnt_we = 1'b1;
                    cnt_wa         = cell_hash[bsel];
                    cnt_wd         = idx_cnt - BVW'(1);
                    if (idx_cnt == BVW'(1))
                    begin
                        idx_ctl.off_we = 1'b1;
                        off_wa         = cell_hash[bsel];
                        off_wd         = BIN_V;
                    end
                    node_ctl.clr_taken = 1'b1;
                    if (live_reg != '0)
                    begin
                        live_next = live_reg - BVW'(1);
                    end
                    removed_next = removed_reg + 8'd1;
                end
                state_next = P_RD;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        count_out_next = done_next ? 8'(live_next) : count_out_reg;
    end

    // State and registered outputs.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            mac_reg       <= '0;
            kind_reg      <= '0;
            h_reg         <= '0;
            cnt_reg       <= '0;
            b_reg         <= '0;
            end_reg       <= '0;
            idx_reg       <= '0;
            e_reg         <= '0;
            n_reg         <= '0;
            fn_reg        <= '0;
            prev_reg      <= '0;
            prev_v_reg    <= 1'b0;
            setpos_reg    <= 1'b0;
            live_reg      <= '0;
            removed_reg   <= '0;
            done_reg      <= 1'b0;
            code_reg      <= '0;
            slot_reg      <= '0;
            count_out_reg <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            mac_reg       <= mac_next;
            kind_reg      <= kind_next;
            h_reg         <= h_next;
            cnt_reg       <= cnt_next;
            b_reg         <= b_next;
            end_reg       <= end_next;
            idx_reg       <= idx_next;
            e_reg         <= e_next;
            n_reg         <= n_next;
            fn_reg        <= fn_next;
            prev_reg      <= prev_next;
            prev_v_reg    <= prev_v_next;
            setpos_reg    <= setpos_next;
            live_reg      <= live_next;
            removed_reg   <= removed_next;
            done_reg      <= done_next;
            code_reg      <= code_next;
            slot_reg      <= slot_next;
            count_out_reg <= count_out_next;
        end
    end

    // Expiry limit register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ft_reg <= FORGET_RESET;
        end
        else if (cfg_wr_en)
        begin
            ft_reg <= cfg_wr_data;
        end
    end

    assign busy          = (state_reg != S_IDLE) || idx_clearing;
    assign done          = done_reg;
    assign result_code   = code_reg;
    assign node_slot     = slot_reg;
    assign node_count    = count_out_reg;
    assign removed_count = removed_reg;

    // The live count never passes the number of bins.
    a_live_bound: assert property (@(posedge clk) disable iff (!rst_n)
        live_reg <= BIN_V)
        else $error("live node count above bin count");

    // A full table reports no slot.
    a_full_slot: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (result_code == RES_FULL)) |-> (node_slot == SLOT_NONE))
        else $error("full result carries a slot");

    // A real command keeps the block busy in the following cycle.
    a_cmd_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && ((cmd == CMD_LEARN) || (cmd == CMD_TICK)
                            || (cmd == CMD_PURGE))) |=> busy)
        else $error("command accepted without work");

endmodule
